@@ sv/ipcc_pkg.sv @@
// types and constants shared by the interval paint coverage counter
// no dependencies
package ipcc_pkg;

    localparam int POS_BITS = 32;

    typedef struct packed {
        logic                func;
        logic [POS_BITS-1:0] first_pos;
        logic [POS_BITS-1:0] last_pos;
    } req_in_t;

    typedef struct packed {
        logic [POS_BITS:0] white_count;
        logic [1:0]        status;
    } req_out_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REVERSED = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_step;
        logic scan_done;
        logic mv_rd;
        logic mv_wr;
        logic ins_wr;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reversed;
        logic scan_end;
        logic full;
        logic mv_end;
        logic ins_end;
    } dp_sts_t;

endpackage

@@ sv/ipcc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ipcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/ipcc_datapath.sv @@
// interval table, scan counters and white count
// depends on ipcc_pkg and ipcc_ram
module ipcc_datapath #(
    parameter int MAX_SPANS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ipcc_pkg::req_in_t   req,
    input  ipcc_pkg::dp_cmd_t   cmd,
    output ipcc_pkg::dp_sts_t   sts,
    output logic [32:0]         white_count
);

    localparam int POS_BITS = ipcc_pkg::POS_BITS;
    localparam int AW = $clog2(MAX_SPANS);
    localparam int CW = $clog2(MAX_SPANS + 1) + 1;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [POS_BITS-1:0] wr_s;
    logic [POS_BITS-1:0] wr_e;
    logic [POS_BITS-1:0] rd_s;
    logic [POS_BITS-1:0] rd_e;

    ipcc_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_SPANS)) u_start (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_s),
        .rd_addr(rd_addr), .rd_data(rd_s)
    );
    ipcc_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_SPANS)) u_end (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_e),
        .rd_addr(rd_addr), .rd_data(rd_e)
    );

    logic                white_reg;
    logic [POS_BITS-1:0] a_reg;
    logic [POS_BITS-1:0] b_reg;
    logic [CW-1:0]       used_reg;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       hi_reg;
    logic                in_range_reg;
    logic [32:0]         covered_reg;
    logic [32:0]         total_reg;
    logic [POS_BITS-1:0] first_s_reg;
    logic [POS_BITS-1:0] last_e_reg;
    logic [CW-1:0]       new_used_reg;
    logic [CW-1:0]       src_reg;
    logic [CW-1:0]       dst_reg;
    logic [1:0]          ins_cnt_reg;
    logic [1:0]          ins_idx_reg;

    // derived piece info
    logic                k_pos;
    logic                lp;
    logic                rp;
    logic [1:0]          ins_need;
    logic [CW-1:0]       k;
    logic [CW+1:0]       need;
    logic [32:0]         new_len;
    logic [32:0]         kept;
    logic [POS_BITS-1:0] ns;
    logic [POS_BITS-1:0] ne;
    logic [POS_BITS-1:0] p0_s;
    logic [POS_BITS-1:0] p0_e;
    logic [POS_BITS-1:0] p1_s;
    logic [POS_BITS-1:0] p1_e;

    always_comb
    begin
        k     = hi_reg - lo_reg;
        k_pos = (hi_reg != lo_reg);
        ns    = (k_pos && first_s_reg < a_reg) ? first_s_reg : a_reg;
        ne    = (k_pos && last_e_reg > b_reg) ? last_e_reg : b_reg;
        lp    = k_pos && (first_s_reg < a_reg);
        rp    = k_pos && (last_e_reg > b_reg);
        p0_s  = white_reg ? ns : (lp ? first_s_reg : b_reg + 1'b1);
        p0_e  = white_reg ? ne : (lp ? a_reg - 1'b1 : last_e_reg);
        p1_s  = b_reg + 1'b1;
        p1_e  = last_e_reg;
        if (white_reg)
        begin
            ins_need = 2'd1;
        end
        else
        begin
            ins_need = {1'b0, lp} + {1'b0, rp};
        end
        need    = {2'b00, used_reg} - {2'b00, k} + {{CW{1'b0}}, ins_need};
        new_len = {1'b0, ne} - {1'b0, ns} + 33'd1;
        kept    = (lp ? ({1'b0, a_reg} - {1'b0, first_s_reg}) : 33'd0)
                + (rp ? ({1'b0, last_e_reg} - {1'b0, b_reg}) : 33'd0);
    end

    // tail entries moved by the signed shift ins_need - k
    logic shift_up;
    always_comb
    begin
        shift_up = ({{CW{1'b0}}, ins_need} > {2'b00, k});
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = dst_reg[AW-1:0];
        wr_s    = rd_s;
        wr_e    = rd_e;
        rd_addr = idx_reg[AW-1:0];
        if (cmd.mv_rd)
        begin
            rd_addr = src_reg[AW-1:0];
        end
        if (cmd.mv_wr)
        begin
            wr_en = 1'b1;
        end
        if (cmd.ins_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(lo_reg + {{(CW-2){1'b0}}, ins_idx_reg});
            wr_s    = (ins_idx_reg == 2'd0) ? p0_s : p1_s;
            wr_e    = (ins_idx_reg == 2'd0) ? p0_e : p1_e;
        end
    end

    assign sts.reversed = (a_reg > b_reg);
    assign sts.scan_end = (idx_reg >= used_reg);
    assign sts.full     = (need > (CW+2)'(MAX_SPANS));
    assign sts.mv_end   = shift_up ? ((src_reg + {{(CW-1){1'b0}}, 1'b1}) == hi_reg)
                                   : (src_reg >= used_reg);
    assign sts.ins_end  = (ins_idx_reg >= ins_cnt_reg);
    assign white_count  = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            total_reg <= '0;
        end
        else if (cmd.commit)
        begin
            used_reg <= new_used_reg;
            if (white_reg)
            begin
                total_reg <= total_reg + new_len - covered_reg;
            end
            else
            begin
                total_reg <= total_reg - (covered_reg - kept);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            white_reg    <= req.func;
            a_reg        <= req.first_pos[POS_BITS-1:0];
            b_reg        <= req.last_pos[POS_BITS-1:0];
            idx_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            in_range_reg <= 1'b0;
            covered_reg  <= '0;
            ins_idx_reg  <= '0;
        end
        if (cmd.scan_rd)
        begin
            idx_reg <= idx_reg;
        end
        if (cmd.scan_step)
        begin
            // rd_s/rd_e hold entry idx_reg
            if (!in_range_reg && rd_e < a_reg)
            begin
                lo_reg  <= idx_reg + 1'b1;
                hi_reg  <= idx_reg + 1'b1;
                idx_reg <= idx_reg + 1'b1;
            end
            else if (rd_s <= b_reg)
            begin
                if (!in_range_reg)
                begin
                    first_s_reg <= rd_s;
                end
                in_range_reg <= 1'b1;
                last_e_reg   <= rd_e;
                covered_reg  <= covered_reg + {1'b0, rd_e} - {1'b0, rd_s} + 33'd1;
                hi_reg       <= idx_reg + 1'b1;
                idx_reg      <= idx_reg + 1'b1;
            end
            else
            begin
                idx_reg <= used_reg;
            end
        end
        if (cmd.scan_done)
        begin
            new_used_reg <= need[CW-1:0];
            ins_cnt_reg  <= ins_need;
            if (shift_up)
            begin
                src_reg <= used_reg - 1'b1;
                dst_reg <= used_reg - 1'b1 + ({{(CW-2){1'b0}}, ins_need} - k);
            end
            else
            begin
                src_reg <= hi_reg;
                dst_reg <= lo_reg + {{(CW-2){1'b0}}, ins_need};
            end
        end
        if (cmd.mv_wr)
        begin
            if (shift_up)
            begin
                src_reg <= src_reg - 1'b1;
                dst_reg <= dst_reg - 1'b1;
            end
            else
            begin
                src_reg <= src_reg + 1'b1;
                dst_reg <= dst_reg + 1'b1;
            end
        end
        if (cmd.ins_wr)
        begin
            ins_idx_reg <= ins_idx_reg + 1'b1;
        end
    end

endmodule

@@ sv/ipcc_ctrl.sv @@
// sequencer for scan, tail shift, insert and result
// depends on ipcc_pkg
module ipcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        out_status,
    output ipcc_pkg::dp_cmd_t cmd,
    input  ipcc_pkg::dp_sts_t sts
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_SRD   = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_DEC   = 9'b000010000,
        S_MRD   = 9'b000100000,
        S_MWR   = 9'b001000000,
        S_INS   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_status = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.reversed)
                begin
                    status_next = ipcc_pkg::ST_REVERSED;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = sts.scan_end ? S_DEC : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                state_next    = S_SRD;
            end
            S_DEC:
            begin
                if (sts.full)
                begin
                    status_next = ipcc_pkg::ST_FULL;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.scan_done = 1'b1;
                    state_next    = S_MRD;
                end
            end
            S_MRD:
            begin
                cmd.mv_rd  = 1'b1;
                state_next = sts.mv_end ? S_INS : S_MWR;
            end
            S_MWR:
            begin
                cmd.mv_wr  = 1'b1;
                state_next = S_MRD;
            end
            S_INS:
            begin
                if (sts.ins_end)
                begin
                    cmd.commit  = 1'b1;
                    status_next = ipcc_pkg::ST_OK;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.ins_wr = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ipcc_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

@@ sv/interval_paint_coverage_counter.sv @@
// Keeps a sorted table of disjoint white intervals and paints one range per
// request, returning the white position count. Each request scans the table
// entry by entry and then shifts the tail entries one at a time; scanned and
// shifted entries together are at most MAX_SPANS + 1, all through the single
// read port of the interval memories. A reversed range answers without a scan.
// One request is in work at a time. No clearing pass is needed after reset.
// depends on ipcc_pkg, ipcc_ctrl, ipcc_datapath
module interval_paint_coverage_counter #(
    parameter int MAX_SPANS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ipcc_pkg::req_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ipcc_pkg::req_out_t out_data
);

    ipcc_pkg::dp_cmd_t cmd;
    ipcc_pkg::dp_sts_t sts;
    logic [1:0]        status;
    logic [32:0]       white_count;

    ipcc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_status(status), .cmd(cmd), .sts(sts)
    );

    ipcc_datapath #(.MAX_SPANS(MAX_SPANS)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data),
        .cmd(cmd), .sts(sts), .white_count(white_count)
    );

    assign out_data.white_count = white_count;
    assign out_data.status      = status;

endmodule

@@ dv/interval_paint_coverage_counter_chk.sv @@
// checker for the interval paint coverage counter: watches both channels,
// keeps its own interval table, predicts each result and compares
// depends on ipcc_pkg
module interval_paint_coverage_counter_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ipcc_pkg::req_in_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ipcc_pkg::req_out_t out_data,
    output int                 fail_count,
    output int                 pending,
    output int                 span_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;

    logic [31:0] white_lo [$];
    logic [31:0] white_hi [$];
    logic [32:0] painted;
    ipcc_pkg::req_out_t expected_counts [$];

    task automatic report(input string what);
        begin
            $display("mismatch at %0t: %s", $realtime, what);
            fail_count = fail_count + 1;
        end
    endtask

    function automatic ipcc_pkg::req_out_t paint(input ipcc_pkg::req_in_t r);
        ipcc_pkg::req_out_t res;
        int          lo;
        int          hi;
        int          need;
        logic [32:0] covered;
        logic [32:0] kept;
        logic [31:0] ns;
        logic [31:0] ne;
        logic        lp;
        logic        rp;
        logic [31:0] rend;
        logic [31:0] lstart;
        begin
            res.status = ipcc_pkg::ST_OK;
            covered = '0;
            kept = '0;
            lp = 1'b0;
            rp = 1'b0;
            if (r.first_pos > r.last_pos) begin
                res.status = ipcc_pkg::ST_REVERSED;
                res.white_count = painted;
                return res;
            end
            lo = 0;
            while (lo < white_lo.size() && white_hi[lo] < r.first_pos)
                lo++;
            hi = lo;
            while (hi < white_lo.size() && white_lo[hi] <= r.last_pos) begin
                covered += 33'(white_hi[hi]) - 33'(white_lo[hi]) + 33'd1;
                hi++;
            end
            ns = r.first_pos;
            ne = r.last_pos;
            lstart = '0;
            rend = '0;
            if (hi > lo) begin
                lstart = white_lo[lo];
                rend = white_hi[hi - 1];
                if (lstart < ns) ns = lstart;
                if (rend > ne) ne = rend;
                lp = lstart < r.first_pos;
                rp = rend > r.last_pos;
            end
            if (r.func)
                need = white_lo.size() - (hi - lo) + 1;
            else
                need = white_lo.size() - (hi - lo) + int'(lp) + int'(rp);
            if (need > TABLE_DEPTH) begin
                res.status = ipcc_pkg::ST_FULL;
                res.white_count = painted;
                return res;
            end
            for (int i = hi - 1; i >= lo; i--)
            begin
                white_lo.delete(i);
                white_hi.delete(i);
            end
            if (r.func) begin
                white_lo.insert(lo, ns);
                white_hi.insert(lo, ne);
                painted = painted + (33'(ne) - 33'(ns) + 33'd1) - covered;
            end else begin
                if (rp) begin
                    white_lo.insert(lo, r.last_pos + 32'd1);
                    white_hi.insert(lo, rend);
                    kept += 33'(rend) - 33'(r.last_pos);
                end
                if (lp) begin
                    white_lo.insert(lo, lstart);
                    white_hi.insert(lo, r.first_pos - 32'd1);
                    kept += 33'(r.first_pos) - 33'(lstart);
                end
                painted = painted - (covered - kept);
            end
            res.white_count = painted;
            return res;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ipcc_pkg::req_out_t want;
        if (!rst_n) begin
            white_lo.delete();
            white_hi.delete();
            painted = '0;
            expected_counts.delete();
            fail_count = 0;
        end else begin
            if (in_valid && !in_stall)
                expected_counts.push_back(paint(in_data));
            if (out_valid && !out_stall) begin
                if (expected_counts.size() == 0) begin
                    report("result with no request waiting");
                end else begin
                    want = expected_counts.pop_front();
                    if (out_data.white_count !== want.white_count)
                        report($sformatf("white_count got %0d want %0d",
                            out_data.white_count, want.white_count));
                    if (out_data.status !== want.status)
                        report($sformatf("status got %0d want %0d",
                            out_data.status, want.status));
                end
            end
        end
        pending = expected_counts.size();
        span_count = white_lo.size();
    end

endmodule

@@ dv/interval_paint_coverage_counter_tb.sv @@
// top of the interval paint coverage counter testbench: clock, reset,
// request stimulus, result stalls and verdict
// depends on ipcc_pkg, interval_paint_coverage_counter, interval_paint_coverage_counter_chk
module interval_paint_coverage_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    ipcc_pkg::req_in_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    ipcc_pkg::req_out_t out_data;
    int                 fail_count;
    int                 pending;
    int                 span_count;
    int                 cycles = 0;
    logic               long_stalls = 1'b0;

    always #1 clk = ~clk;

    interval_paint_coverage_counter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    interval_paint_coverage_counter_chk checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending), .span_count(span_count)
    );

    function automatic int gap_len();
        begin
            if ($urandom_range(0, 19) == 0)
                return $urandom_range(10, 60);
            if ($urandom_range(0, 2) == 0)
                return $urandom_range(1, 3);
            return 0;
        end
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("interval_paint_coverage_counter_tb: done, errors");
            $finish;
        end
        if (long_stalls)
            out_stall <= ($urandom_range(0, 99) < 60);
        else
            out_stall <= ($urandom_range(0, 99) < 15);
    end

    task automatic send(input logic f, input logic [31:0] a, input logic [31:0] b);
        int gap;
        begin
            gap = gap_len();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= '{func: f, first_pos: a, last_pos: b};
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
        end
    endtask

    task automatic send_random();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] w;
        int          mode;
        begin
            mode = $urandom_range(0, 99);
            if (mode < 70) begin
                a = $urandom_range(0, 4000);
                w = $urandom_range(0, 40);
            end else if (mode < 85) begin
                a = $urandom;
                w = $urandom_range(0, 1000);
            end else begin
                a = $urandom;
                w = $urandom;
            end
            b = (a + w < a) ? 32'hffff_ffff : a + w;
            if ($urandom_range(0, 19) == 0)
                send(1'($urandom_range(0, 1)), b, a - 32'd1);
            else
                send(1'($urandom_range(0, 1)), a, b);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(1'b1, 32'd0, 32'd0);
        send(1'b1, 32'hffff_ffff, 32'hffff_ffff);
        send(1'b1, 32'd10, 32'd20);
        send(1'b1, 32'd21, 32'd30);
        send(1'b1, 32'd15, 32'd25);
        send(1'b0, 32'd12, 32'd14);
        send(1'b0, 32'd10, 32'd11);
        send(1'b0, 32'd30, 32'd30);
        send(1'b0, 32'd5, 32'd9);
        send(1'b1, 32'd5, 32'd2);
        send(1'b0, 32'hffff_ffff, 32'd0);
        send(1'b1, 32'd0, 32'hffff_ffff);
        send(1'b0, 32'd1, 32'hffff_fffe);
        send(1'b0, 32'd0, 32'hffff_ffff);
        send(1'b1, 32'haaaa_aaaa, 32'hd555_5555);
        send(1'b0, 32'h5555_5555, 32'hbbbb_bbbb);
        // fill the table to capacity then overflow it
        for (int i = 0; i < 256; i++)
            send(1'b1, 32'(i * 4), 32'(i * 4 + 1));
        send(1'b1, 32'd5000, 32'd5000);
        send(1'b0, 32'd8, 32'd8);
        send(1'b1, 32'd0, 32'd1030);
        drain();
        for (int i = 0; i < 400; i++)
        begin
            long_stalls <= (i > 300 && i < 360);
            send_random();
        end
        drain();
        for (int i = 0; i < 495; i++)
        begin
            if (i == 400)
                send(1'b0, 32'd0, 32'hffff_ffff);
            else
                send_random();
        end
        drain();
        repeat (2000) @(posedge clk);
        if (fail_count == 0)
            $display("interval_paint_coverage_counter_tb: done, clean");
        else
            $display("interval_paint_coverage_counter_tb: done, errors");
        $finish;
    end

endmodule
